### hw/rtl/msblit_pkg.sv
// msblit_pkg: shared types and constants of the masked sprite blitter
// holds command and response words, opcodes, controller states and control structs
// no dependencies
`default_nettype none

package msblit_pkg;

    // fixed geometry of the frame buffer and of a sprite row
    localparam int WORDS_PER_ROW = 32;
    localparam int TILES_PER_ROW = 4;
    localparam int PIX_W         = 16;

    localparam logic [PIX_W-1:0] FILL_WHITE = 16'hFFFF;
    localparam logic [PIX_W-1:0] FILL_BLACK = 16'h0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_DRAW  = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    // one incoming command word
    typedef struct packed {
        opcode_t     opcode;
        logic [3:0]  sprite_slot;
        logic [7:0]  sprite_word;
        logic [15:0] color_bits;
        logic [15:0] alpha_bits;
        logic        clear_white;
        logic [8:0]  pos_x;
        logic [7:0]  pos_y;
        logic [12:0] read_address;
    } cmd_word_t;

    // one outgoing response word
    typedef struct packed {
        opcode_t     done_opcode;
        logic [15:0] read_data;
    } rsp_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_DRAW_INIT,
        ST_DRAW_RDA,
        ST_DRAW_WRA,
        ST_DRAW_WRB,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    // frame buffer read address select
    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_RED
    } rd_sel_t;

    // frame buffer write select
    typedef enum logic [1:0] {
        WR_NONE,
        WR_FILL,
        WR_A,
        WR_B
    } wr_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    spr_we;
        logic    clr_step;
        logic    red_step;
        logic    draw_start;
        logic    next_word;
        logic    capture_read;
        logic    push;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic slot_ok;
        logic red_ok;
        logic shift_nz;
        logic last_word;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/msblit_ram.sv
// msblit_ram: generic simple dual port ram, one write port, one registered read port
// depends on nothing
`default_nettype none

module msblit_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/msblit_ctrl.sv
// msblit_ctrl: command sequencer of the sprite blitter
// depends on msblit_pkg; drives the datapath through ctrl_cmd_t, reads dp_status_t
`default_nettype none

module msblit_ctrl
    import msblit_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire opcode_t    cmd_opcode,
    output logic            cmd_stall,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_opcode)
                        OP_LOAD:  state_next = ST_LOAD;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_DRAW:  state_next = ST_DRAW_INIT;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DRAW_INIT:
            begin
                if (!status.slot_ok)
                begin
                    state_next = ST_DONE;
                end
                else if (status.red_ok)
                begin
                    state_next = ST_DRAW_RDA;
                end
            end
            ST_DRAW_RDA:
            begin
                state_next = ST_DRAW_WRA;
            end
            ST_DRAW_WRA:
            begin
                if (status.shift_nz)
                begin
                    state_next = ST_DRAW_WRB;
                end
                else if (status.last_word)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DRAW_RDA;
                end
            end
            ST_DRAW_WRB:
            begin
                state_next = status.last_word ? ST_DONE : ST_DRAW_RDA;
            end
            ST_READ:
            begin
                if (status.red_ok)
                begin
                    state_next = ST_READ_WAIT;
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        cmd.rd_sel = RD_A;
        cmd.wr_sel = WR_NONE;
        cmd_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall   = 1'b0;
                cmd.capture = cmd_valid;
            end
            ST_LOAD:
            begin
                cmd.spr_we = 1'b1;
            end
            ST_CLEAR:
            begin
                cmd.wr_sel   = WR_FILL;
                cmd.clr_step = 1'b1;
            end
            ST_DRAW_INIT:
            begin
                cmd.draw_start = status.slot_ok && status.red_ok;
                cmd.red_step   = status.slot_ok && !status.red_ok;
            end
            ST_DRAW_RDA:
            begin
                cmd.rd_sel = RD_A;
            end
            ST_DRAW_WRA:
            begin
                cmd.wr_sel    = WR_A;
                cmd.rd_sel    = RD_B;
                cmd.next_word = !status.shift_nz;
            end
            ST_DRAW_WRB:
            begin
                cmd.wr_sel    = WR_B;
                cmd.next_word = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_sel   = RD_RED;
                cmd.red_step = !status.red_ok;
            end
            ST_READ_WAIT:
            begin
                cmd.capture_read = 1'b1;
            end
            ST_DONE:
            begin
                cmd.push = status.out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/msblit_datapath.sv
// msblit_datapath: sprite stores, frame buffer, address walk, blend and response register
// depends on msblit_pkg and msblit_ram; steered by msblit_ctrl through ctrl_cmd_t
`default_nettype none

module msblit_datapath
    import msblit_pkg::*;
#(
    parameter int SPRITE_SLOTS = 16,
    parameter int SPRITE_ROWS  = 64,
    parameter int BUFFER_ROWS  = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_word_t cmd_word,
    input  wire ctrl_cmd_t cmd,
    output dp_status_t     status,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp_word
);

    localparam int WPS       = SPRITE_ROWS * TILES_PER_ROW;
    localparam int SPR_DEPTH = SPRITE_SLOTS * WPS;
    localparam int SAW       = $clog2(SPR_DEPTH);
    localparam int BUF_DEPTH = BUFFER_ROWS * WORDS_PER_ROW;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int RW        = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;
    localparam int RED_W     = 13;

    localparam logic [AW:0]      DEPTH_X   = (AW+1)'(BUF_DEPTH);
    localparam logic [AW-1:0]    DEPTH_M1  = AW'(BUF_DEPTH - 1);
    localparam logic [RED_W-1:0] DEPTH_RED = RED_W'(BUF_DEPTH);
    localparam logic [RW-1:0]    ROW_LAST  = RW'(SPRITE_ROWS - 1);
    localparam logic [AW:0]      ROW_STEP  = (AW+1)'(WORDS_PER_ROW);

    // captured command
    opcode_t          op_reg;
    logic [15:0]      color_reg;
    logic [15:0]      alpha_reg;
    logic [15:0]      fill_reg;
    logic [3:0]       shift_reg;
    logic             slot_ok_reg;
    logic             word_ok_reg;

    // walk state
    logic [SAW-1:0]   spr_idx_reg;
    logic [SAW-1:0]   spr_idx_next;
    logic [RED_W-1:0] red_reg;
    logic [AW-1:0]    row_start_reg;
    logic [1:0]       tile_reg;
    logic [RW-1:0]    row_reg;
    logic [AW-1:0]    clr_reg;
    logic [15:0]      res_reg;

    // response register
    logic             rsp_valid_reg;
    rsp_word_t        rsp_word_reg;

    // ram ports
    logic [15:0]      spr_color_rd;
    logic [15:0]      spr_alpha_rd;
    logic [15:0]      buf_rd;
    logic [AW-1:0]    buf_raddr;
    logic [AW-1:0]    buf_waddr;
    logic [15:0]      buf_wdata;
    logic             buf_we;

    // address and blend terms
    logic [AW:0]      sum_a;
    logic [AW:0]      sum_b;
    logic [AW:0]      sum_row;
    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;
    logic [AW-1:0]    row_wrap;
    logic [31:0]      color_sh;
    logic [31:0]      alpha_sh;
    logic [15:0]      blend_a;
    logic [15:0]      blend_b;
    logic             red_ok;

    // wrapped buffer addresses of the current sprite word
    always_comb
    begin
        sum_a    = {1'b0, row_start_reg} + (AW+1)'(tile_reg);
        sum_b    = sum_a + (AW+1)'(1);
        sum_row  = {1'b0, row_start_reg} + ROW_STEP;
        addr_a   = (sum_a >= DEPTH_X) ? AW'(sum_a - DEPTH_X) : sum_a[AW-1:0];
        addr_b   = (sum_b >= DEPTH_X) ? AW'(sum_b - DEPTH_X) : sum_b[AW-1:0];
        row_wrap = (sum_row >= DEPTH_X) ? AW'(sum_row - DEPTH_X) : sum_row[AW-1:0];
        red_ok   = 32'(red_reg) < BUF_DEPTH;
    end

    // split tile: high half lands in word a, low half in word b
    always_comb
    begin
        color_sh = {spr_color_rd, 16'h0000} >> shift_reg;
        alpha_sh = {spr_alpha_rd, 16'h0000} >> shift_reg;
        blend_a  = (alpha_sh[31:16] & color_sh[31:16]) | (~alpha_sh[31:16] & buf_rd);
        blend_b  = (alpha_sh[15:0] & color_sh[15:0]) | (~alpha_sh[15:0] & buf_rd);
    end

    // sprite index walk, the store is read at the next index every cycle
    always_comb
    begin
        spr_idx_next = spr_idx_reg;
        if (cmd.capture)
        begin
            spr_idx_next = SAW'(32'(cmd_word.sprite_slot) * WPS
                + ((cmd_word.opcode == OP_LOAD) ? 32'(cmd_word.sprite_word) : 32'd0));
        end
        else if (cmd.next_word)
        begin
            spr_idx_next = spr_idx_reg + SAW'(1);
        end
    end

    // frame buffer port selection
    always_comb
    begin
        case (cmd.rd_sel)
            RD_B:    buf_raddr = addr_b;
            RD_RED:  buf_raddr = AW'(red_reg);
            default: buf_raddr = addr_a;
        endcase
        buf_we    = 1'b1;
        buf_waddr = addr_a;
        buf_wdata = blend_a;
        case (cmd.wr_sel)
            WR_FILL:
            begin
                buf_waddr = clr_reg;
                buf_wdata = fill_reg;
            end
            WR_A:
            begin
                buf_waddr = addr_a;
                buf_wdata = blend_a;
            end
            WR_B:
            begin
                buf_waddr = addr_b;
                buf_wdata = blend_b;
            end
            default:
            begin
                buf_we = 1'b0;
            end
        endcase
    end

    // command capture, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= cmd_word.opcode;
            color_reg   <= cmd_word.color_bits;
            alpha_reg   <= cmd_word.alpha_bits;
            fill_reg    <= cmd_word.clear_white ? FILL_WHITE : FILL_BLACK;
            shift_reg   <= cmd_word.pos_x[3:0];
            slot_ok_reg <= 32'(cmd_word.sprite_slot) < SPRITE_SLOTS;
            word_ok_reg <= 32'(cmd_word.sprite_word) < WPS;
        end
    end

    // address walk registers
    always_ff @(posedge clk)
    begin
        spr_idx_reg <= spr_idx_next;
        if (cmd.capture)
        begin
            red_reg <= (cmd_word.opcode == OP_READ) ? cmd_word.read_address
                                                    : {cmd_word.pos_y, cmd_word.pos_x[8:4]};
            clr_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (cmd.red_step)
            begin
                red_reg <= red_reg - DEPTH_RED;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.capture_read)
            begin
                res_reg <= buf_rd;
            end
        end
        if (cmd.draw_start)
        begin
            row_start_reg <= AW'(red_reg);
            tile_reg      <= '0;
            row_reg       <= '0;
        end
        else if (cmd.next_word)
        begin
            tile_reg <= tile_reg + 2'd1;
            if (tile_reg == 2'd3)
            begin
                row_reg       <= row_reg + RW'(1);
                row_start_reg <= row_wrap;
            end
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            rsp_word_reg.done_opcode <= op_reg;
            rsp_word_reg.read_data   <= (op_reg == OP_READ) ? res_reg : 16'h0000;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // status back to the controller
    always_comb
    begin
        status.slot_ok   = slot_ok_reg;
        status.red_ok    = red_ok;
        status.shift_nz  = shift_reg != 4'd0;
        status.last_word = (tile_reg == 2'd3) && (row_reg == ROW_LAST);
        status.clr_last  = clr_reg == DEPTH_M1;
        status.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    // sprite colour and mask stores
    msblit_ram #(
        .WIDTH (16),
        .DEPTH (SPR_DEPTH)
    ) u_color_ram (
        .clk   (clk),
        .we    (cmd.spr_we && slot_ok_reg && word_ok_reg),
        .waddr (spr_idx_reg),
        .wdata (color_reg),
        .raddr (spr_idx_next),
        .rdata (spr_color_rd)
    );

    msblit_ram #(
        .WIDTH (16),
        .DEPTH (SPR_DEPTH)
    ) u_alpha_ram (
        .clk   (clk),
        .we    (cmd.spr_we && slot_ok_reg && word_ok_reg),
        .waddr (spr_idx_reg),
        .wdata (alpha_reg),
        .raddr (spr_idx_next),
        .rdata (spr_alpha_rd)
    );

    // frame buffer
    msblit_ram #(
        .WIDTH (16),
        .DEPTH (BUF_DEPTH)
    ) u_buf_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rd)
    );

`ifndef ASSERT_OFF
    // a pushed response shows up with the captured opcode
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (rsp_valid_reg && rsp_word_reg.done_opcode == $past(op_reg)))
        else $error("response not registered after push");

    // push never overwrites a stalled response
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response overwritten while stalled");

    // every buffer write stays inside the buffer once addresses are wrapped
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_we |-> (32'(buf_waddr) < BUF_DEPTH))
        else $error("frame buffer write address out of range");

    // only read commands carry data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_word_reg.done_opcode != OP_READ)
            |-> (rsp_word_reg.read_data == 16'h0000))
        else $error("nonzero data on a non-read response");
`endif

endmodule

`default_nettype wire

### hw/rtl/masked_sprite_blitter_1bpp_top.sv
// a clear writes every frame buffer word once; a draw first reduces the start address into the
// buffer, then blends each sprite word into one buffer word (aligned x) or two (unaligned x),
// walking the sprite row by row through the single frame buffer port pair
// one command is in flight at a time; the next is taken once the response is registered
// reset clears the controller and the response valid only; sprite stores and frame buffer
// hold unknown data until loaded or cleared, there is no clearing pass after reset
`default_nettype none

module masked_sprite_blitter_1bpp_top
    import msblit_pkg::*;
#(
    parameter int SPRITE_SLOTS = 16,
    parameter int SPRITE_ROWS  = 64,
    parameter int BUFFER_ROWS  = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_word_t cmd_word,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp_word
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    msblit_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_opcode (cmd_word.opcode),
        .cmd_stall  (cmd_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // memories, address walk and response register
    msblit_datapath #(
        .SPRITE_SLOTS (SPRITE_SLOTS),
        .SPRITE_ROWS  (SPRITE_ROWS),
        .BUFFER_ROWS  (BUFFER_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

`default_nettype wire
